FILE: sv/rdft_pkg.sv
// Shared constants, types and twiddle tables for the packed real DFT block.
// Used by every module of the block; it depends on nothing else.
package rdft_pkg;

    localparam int POINTS = 32;
    localparam int FRAC   = 15;

    // POINTS is expected to be a power of two so that the inverse scaling is a shift.
    localparam int IDX_W       = $clog2(POINTS);
    localparam int LOG2_POINTS = $clog2(POINTS);
    localparam int OUT_IDX_W   = 6;
    localparam int DATA_W      = 32;
    localparam int TW_W        = FRAC + 2;
    localparam int PROD_W      = DATA_W + TW_W;
    localparam int RND_W       = PROD_W - FRAC;
    localparam int ACC_W       = RND_W + $clog2(POINTS + 1) + 1;
    localparam int ADDR_W      = 3;

    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(POINTS - 1);
    localparam bit                POINTS_EVEN = (POINTS % 2) == 0;
    localparam logic [PROD_W-1:0] RND_HALF    = PROD_W'(1) << (FRAC - 1);
    localparam logic [ACC_W-1:0]  HALF_POINTS = ACC_W'(POINTS / 2);
    localparam logic [ACC_W-1:0]  POS_LIM     = ACC_W'(32'h7FFF_FFFF);
    localparam logic [ACC_W-1:0]  NEG_LIM     = ACC_W'(32'h8000_0000);

    // Register word index on the configuration port.
    localparam logic REG_DIRECTION = 1'b0;

    typedef logic signed [TW_W-1:0] tw_tab_t [POINTS];

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } store_req_t;

    typedef struct packed {
        logic                   valid;
        logic                   first;
        logic                   dbl;
        logic                   corr_en;
        logic                   corr_neg;
        logic                   div_load;
        logic                   inv;
        logic signed [TW_W-1:0] tw;
    } mac_ctl_t;

    // Cosine and sine of 2*pi*m/POINTS at FRAC fraction bits, rounded half away
    // from zero. The entries are laid out for POINTS = 32 and FRAC = 15.
    localparam tw_tab_t COS_TAB = '{
        17'sd32768,  17'sd32138,  17'sd30274,  17'sd27246,  17'sd23170,  17'sd18205,
        17'sd12540,  17'sd6393,   17'sd0,      -17'sd6393,  -17'sd12540, -17'sd18205,
        -17'sd23170, -17'sd27246, -17'sd30274, -17'sd32138, -17'sd32768, -17'sd32138,
        -17'sd30274, -17'sd27246, -17'sd23170, -17'sd18205, -17'sd12540, -17'sd6393,
        17'sd0,      17'sd6393,   17'sd12540,  17'sd18205,  17'sd23170,  17'sd27246,
        17'sd30274,  17'sd32138
    };

    localparam tw_tab_t SIN_TAB = '{
        17'sd0,      17'sd6393,   17'sd12540,  17'sd18205,  17'sd23170,  17'sd27246,
        17'sd30274,  17'sd32138,  17'sd32768,  17'sd32138,  17'sd30274,  17'sd27246,
        17'sd23170,  17'sd18205,  17'sd12540,  17'sd6393,   17'sd0,      -17'sd6393,
        -17'sd12540, -17'sd18205, -17'sd23170, -17'sd27246, -17'sd30274, -17'sd32138,
        -17'sd32768, -17'sd32138, -17'sd30274, -17'sd27246, -17'sd23170, -17'sd18205,
        -17'sd12540, -17'sd6393
    };

endpackage

FILE: sv/rdft_store.sv
// Value store of the packed real DFT block: one write port, one registered read port.
// Depends on rdft_pkg for sizes and the store request type.
module rdft_store (
    input  logic                       aclk,
    input  rdft_pkg::store_req_t       req,
    input  logic [rdft_pkg::DATA_W-1:0] wr_data,
    output logic [rdft_pkg::DATA_W-1:0] rd_data
);
    import rdft_pkg::*;

    logic [DATA_W-1:0] store_mem [POINTS];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            store_mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= store_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/rdft_mac.sv
// Shared multiply-accumulate unit with rounding, inverse scaling and saturation.
// Depends on rdft_pkg for widths, the control struct and rounding constants.
module rdft_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rdft_pkg::mac_ctl_t                ctl,
    input  logic signed [rdft_pkg::DATA_W-1:0] rd_data,
    output logic signed [rdft_pkg::DATA_W-1:0] res_value
);
    import rdft_pkg::*;

    // Stage 1: control aligned with the registered store read.
    logic                     v1_reg, first1_reg, dbl1_reg, corr_en1_reg, corr_neg1_reg;
    logic signed [TW_W-1:0]   tw1_reg;
    // Stage 2: product and correction term.
    logic                     v2_reg, first2_reg, dbl2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  corr_reg;
    // Accumulator and final scaling.
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]         mag_reg, mag_next;
    logic                     neg_reg, inv_reg;

    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [RND_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  rnd_ext, term, val_ext;
    logic [ACC_W-1:0]         acc_u, half, q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
        end
    end

    assign val_ext = ACC_W'(rd_data);

    always_ff @(posedge aclk) begin
        first1_reg    <= ctl.first;
        dbl1_reg      <= ctl.dbl;
        corr_en1_reg  <= ctl.corr_en;
        corr_neg1_reg <= ctl.corr_neg;
        tw1_reg       <= ctl.tw;
        first2_reg    <= first1_reg;
        dbl2_reg      <= dbl1_reg;
        prod_reg      <= rd_data * tw1_reg;
        if (corr_en1_reg) begin
            corr_reg <= corr_neg1_reg ? -val_ext : val_ext;
        end else begin
            corr_reg <= '0;
        end
        if (v2_reg) begin
            acc_reg <= acc_next;
        end
        if (ctl.div_load) begin
            mag_reg <= mag_next;
            neg_reg <= acc_reg[ACC_W-1];
            inv_reg <= ctl.inv;
        end
    end

    // Adding half an LSB and dropping the fraction rounds half toward plus infinity.
    assign prod_rnd = prod_reg + signed'(RND_HALF);
    assign rnd      = prod_rnd[PROD_W-1:FRAC];
    assign rnd_ext  = ACC_W'(rnd);
    assign term     = dbl2_reg ? (rnd_ext <<< 1) : rnd_ext;
    assign acc_next = (first2_reg ? ACC_W'(0) : acc_reg) + term - corr_reg;

    // Magnitude plus half the divisor, so the shift rounds half away from zero.
    assign acc_u    = acc_reg;
    assign half     = ctl.inv ? HALF_POINTS : '0;
    assign mag_next = acc_reg[ACC_W-1] ? (half - acc_u) : (acc_u + half);

    assign q = inv_reg ? (mag_reg >> LOG2_POINTS) : mag_reg;

    always_comb begin
        if (neg_reg) begin
            res_value = (q > NEG_LIM) ? signed'(32'h8000_0000) : -signed'(q[DATA_W-1:0]);
        end else begin
            res_value = (q > POS_LIM) ? signed'(32'h7FFF_FFFF) : signed'(q[DATA_W-1:0]);
        end
    end

endmodule

FILE: sv/rdft_ctrl.sv
// Sequencer of the packed real DFT block: loads words, walks the store once per
// result, steps the twiddle index and hands results to the output register.
// Depends on rdft_pkg for sizes, twiddle tables and the control structs.
module rdft_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          direction,
    input  logic                          out_free,
    output rdft_pkg::store_req_t          st_req,
    output rdft_pkg::mac_ctl_t            mac_ctl,
    output logic                          out_load,
    output logic [rdft_pkg::OUT_IDX_W-1:0] out_idx,
    output logic                          out_last
);
    import rdft_pkg::*;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0] m_reg, m_next;
    logic             inv_reg, inv_next;
    logic             drain_reg, drain_next;

    logic             accept;
    logic [IDX_W:0]   j_wide;
    logic [IDX_W-1:0] step;
    logic [IDX_W:0]   m_sum;
    logic             step_en, use_sin, last_addr, last_idx;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_LOAD);
    assign last_addr = (addr_reg == LAST_IDX);
    assign last_idx  = (idx_reg == LAST_IDX);

    // Forward frequency j for packed index idx: idx 0 is j = 0 on the cosine table.
    assign j_wide = ({1'b0, idx_reg} + (IDX_W + 1)'(1)) >> 1;
    assign step   = inv_reg ? idx_reg : j_wide[IDX_W-1:0];
    // Inverse pairs addresses 2k-1 and 2k on the same angle, so it steps before odd ones.
    assign step_en = !inv_reg || !addr_reg[0];
    assign m_sum   = {1'b0, m_reg} + {1'b0, step};

    always_comb begin
        if (inv_reg) begin
            use_sin = !addr_reg[0] && (addr_reg != '0);
        end else begin
            use_sin = !idx_reg[0] && (idx_reg != '0);
        end
    end

    always_comb begin
        st_req.wr_en   = accept;
        st_req.wr_addr = cnt_reg;
        st_req.rd_en   = (state_reg == S_ISSUE);
        st_req.rd_addr = addr_reg;

        mac_ctl.valid    = (state_reg == S_ISSUE);
        mac_ctl.first    = (addr_reg == '0);
        mac_ctl.dbl      = inv_reg && (addr_reg != '0);
        mac_ctl.corr_en  = inv_reg && POINTS_EVEN && last_addr;
        mac_ctl.corr_neg = idx_reg[0];
        mac_ctl.div_load = (state_reg == S_DIV);
        mac_ctl.inv      = inv_reg;
        mac_ctl.tw       = use_sin ? SIN_TAB[m_reg] : COS_TAB[m_reg];
    end

    assign out_load = (state_reg == S_OUT) && out_free;
    assign out_idx  = OUT_IDX_W'(idx_reg);
    assign out_last = last_idx;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        addr_next  = addr_reg;
        m_next     = m_reg;
        inv_next   = inv_reg;
        drain_next = drain_reg;
        case (state_reg)
            S_LOAD: begin
                if (accept) begin
                    if (cnt_reg == LAST_IDX) begin
                        cnt_next   = '0;
                        inv_next   = direction;
                        idx_next   = '0;
                        addr_next  = '0;
                        m_next     = '0;
                        state_next = S_ISSUE;
                    end else begin
                        cnt_next = cnt_reg + IDX_W'(1);
                    end
                end
            end
            S_ISSUE: begin
                addr_next = addr_reg + IDX_W'(1);
                if (step_en) begin
                    if (m_sum >= (IDX_W + 1)'(POINTS)) begin
                        m_next = IDX_W'(m_sum - (IDX_W + 1)'(POINTS));
                    end else begin
                        m_next = m_sum[IDX_W-1:0];
                    end
                end
                if (last_addr) begin
                    drain_next = 1'b0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    addr_next = '0;
                    m_next    = '0;
                    if (last_idx) begin
                        state_next = S_LOAD;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_ISSUE;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            addr_reg  <= '0;
            m_reg     <= '0;
            inv_reg   <= 1'b0;
            drain_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            addr_reg  <= addr_next;
            m_reg     <= m_next;
            inv_reg   <= inv_next;
            drain_reg <= drain_next;
        end
    end

endmodule

FILE: sv/real_dft_packed_coefficients.sv
// Top level of the packed real DFT block: configuration register, output register
// and the wiring of store, sequencer and shared MAC.
// Depends on rdft_pkg, rdft_store, rdft_mac and rdft_ctrl.
//
//   Channel   Direction  Handshake          Contents
//   s_        in         s_tvalid/s_tready  one sample or packed coefficient
//   m_        out        m_tvalid/m_tready  one result word, m_tlast on the final one
//   APB       in/out     psel/penable       direction register at word 0
//
// A set loads POINTS words at one per cycle. Each result then takes POINTS passes
// through the single multiply-accumulate unit, a pipeline drain, a scaling step
// and a move into the output register; s_tready stays low while the set is processed.
// Reset is synchronous and active low and clears the load count and the direction.
// A stalled m_tready holds the sequencer at the output step without losing a word.
module real_dft_packed_coefficients (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] in_value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // [31:0] out_value, [37:32] out_index
    output logic                          m_tlast,   // last_result
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rdft_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rdft_pkg::*;

    logic                     direction_reg;
    logic                     m_tvalid_reg;
    logic [DATA_W-1:0]        out_value_reg;
    logic [OUT_IDX_W-1:0]     out_index_reg;
    logic                     out_last_reg;

    store_req_t               st_req;
    mac_ctl_t                 mac_ctl;
    logic [DATA_W-1:0]        rd_data;
    logic signed [DATA_W-1:0] res_value;
    logic                     out_free, out_load, out_last;
    logic [OUT_IDX_W-1:0]     out_idx;
    logic                     reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_DIRECTION);
    assign prdata  = reg_hit ? {31'b0, direction_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            direction_reg <= pwdata[0];
        end
    end

    rdft_store u_store (
        .aclk    (aclk),
        .req     (st_req),
        .wr_data (s_tdata),
        .rd_data (rd_data)
    );

    rdft_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .direction (direction_reg),
        .out_free  (out_free),
        .st_req    (st_req),
        .mac_ctl   (mac_ctl),
        .out_load  (out_load),
        .out_idx   (out_idx),
        .out_last  (out_last)
    );

    rdft_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (mac_ctl),
        .rd_data   (signed'(rd_data)),
        .res_value (res_value)
    );

    // The output register takes a new word when empty or when its word leaves now.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_value_reg <= res_value;
            out_index_reg <= out_idx;
            out_last_reg  <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_index_reg, out_value_reg};
    assign m_tlast  = out_last_reg;

endmodule
